>>> hdl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; used by lpht_ctrl, lpht_dp and the top level.
package lpht_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned KeyInW = 64;
  localparam int unsigned ValW = 32;
  localparam int unsigned SlotW = 10;
  localparam int unsigned StatW = 3;

  typedef enum logic [StatW-1:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_HASH = 3'd4
  } lpht_status_e;

  typedef struct packed {
    logic         ready;
    logic         load;
    logic         alloc;
    logic         grow;
    logic         clr_step;
    logic         scan_rd;
    logic         scan_take;
    logic         scan_next;
    logic         mod_start;
    logic         probe_start;
    logic         probe_rd;
    logic         probe_next;
    logic         place;
    logic         set_res;
    logic         emit;
    logic         src_moved;
    lpht_status_e code;
  } lpht_cmd_t;

  typedef struct packed {
    logic op_insert;
    logic hash_zero;
    logic cap_zero;
    logic want_grow;
    logic full;
    logic clr_last;
    logic scan_end;
    logic rd_used;
    logic rd_match;
    logic probe_last;
    logic mod_done;
    logic out_free;
  } lpht_stat_t;

endpackage

>>> hdl/lpht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lpht_mod.sv
// Iterative remainder unit: 32-bit dividend modulo a capacity, one bit per cycle.
// No dependencies.
module lpht_mod #(
  parameter int unsigned DivW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [31:0]     dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic [DivW-1:0] rem_o,
  output logic            done_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [31:0]     dvd_q, dvd_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      rem_d = trial[DivW-1:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

>>> hdl/lpht_ctrl.sv
// Controller FSM: sequences clear, rehash, modulo and probe steps of the datapath.
// Depends on lpht_pkg.
module lpht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lpht_pkg::lpht_stat_t st_i,
  output lpht_pkg::lpht_cmd_t  cmd_o
);
  import lpht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CLEAR, S_SCAN_RD, S_SCAN_WT, S_INS_CHK,
    S_MOD, S_PROBE_RD, S_PROBE_WT, S_DONE
  } state_e;

  state_e    state_q, state_d;
  logic      rehash_q, rehash_d;
  lpht_cmd_t cmd;

  always_comb begin
    state_d       = state_q;
    rehash_d      = rehash_q;
    cmd           = '0;
    cmd.code      = ST_NOT_FOUND;
    cmd.src_moved = rehash_q;
    unique case (state_q)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (!st_i.op_insert) begin
          if (st_i.cap_zero) begin
            cmd.set_res = 1'b1;
            state_d     = S_DONE;
          end else begin
            cmd.mod_start = 1'b1;
            state_d       = S_MOD;
          end
        end else if (st_i.hash_zero) begin
          cmd.set_res = 1'b1;
          cmd.code    = ST_ZERO_HASH;
          state_d     = S_DONE;
        end else if (st_i.cap_zero) begin
          cmd.alloc = 1'b1;
          state_d   = S_CLEAR;
        end else if (st_i.want_grow) begin
          cmd.grow = 1'b1;
          rehash_d = 1'b1;
          state_d  = S_CLEAR;
        end else begin
          state_d = S_INS_CHK;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st_i.clr_last) begin
          state_d = rehash_q ? S_SCAN_RD : S_INS_CHK;
        end
      end
      S_SCAN_RD: begin
        if (st_i.scan_end) begin
          rehash_d = 1'b0;
          state_d  = S_INS_CHK;
        end else begin
          cmd.scan_rd = 1'b1;
          state_d     = S_SCAN_WT;
        end
      end
      S_SCAN_WT: begin
        if (st_i.rd_used) begin
          cmd.scan_take = 1'b1;
          cmd.mod_start = 1'b1;
          state_d       = S_MOD;
        end else begin
          cmd.scan_next = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_INS_CHK: begin
        if (st_i.full) begin
          cmd.set_res = 1'b1;
          cmd.code    = ST_FULL;
          state_d     = S_DONE;
        end else begin
          cmd.mod_start = 1'b1;
          state_d       = S_MOD;
        end
      end
      S_MOD: begin
        if (st_i.mod_done) begin
          cmd.probe_start = 1'b1;
          state_d         = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        cmd.probe_rd = 1'b1;
        state_d      = S_PROBE_WT;
      end
      S_PROBE_WT: begin
        if (!st_i.op_insert) begin
          priority if (!st_i.rd_used) begin
            cmd.set_res = 1'b1;
            state_d     = S_DONE;
          end else if (st_i.rd_match) begin
            cmd.set_res = 1'b1;
            cmd.code    = ST_FOUND;
            state_d     = S_DONE;
          end else if (st_i.probe_last) begin
            cmd.set_res = 1'b1;
            state_d     = S_DONE;
          end else begin
            cmd.probe_next = 1'b1;
            state_d        = S_PROBE_RD;
          end
        end else if (!st_i.rd_used) begin
          cmd.place = 1'b1;
          if (rehash_q) begin
            cmd.scan_next = 1'b1;
            state_d       = S_SCAN_RD;
          end else begin
            cmd.set_res = 1'b1;
            cmd.code    = ST_INSERTED;
            state_d     = S_DONE;
          end
        end else begin
          cmd.probe_next = 1'b1;
          state_d        = S_PROBE_RD;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd.emit = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rehash_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rehash_q <= rehash_d;
    end
  end

  assign cmd_o = cmd;

endmodule

>>> hdl/lpht_dp.sv
// Datapath: slot memory, table size and count, probe and rehash counters, result register.
// Depends on lpht_pkg, lpht_ram and lpht_mod.
module lpht_dp #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned INITIAL_SLOTS = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpht_pkg::lpht_cmd_t          cmd_i,
  output lpht_pkg::lpht_stat_t         st_o,
  input  logic                         in_op_i,
  input  logic [lpht_pkg::HashW-1:0]   in_hash_i,
  input  logic [lpht_pkg::KeyInW-1:0]  in_key_i,
  input  logic [lpht_pkg::ValW-1:0]    in_val_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lpht_pkg::StatW-1:0]   out_status_o,
  output logic [lpht_pkg::ValW-1:0]    out_value_o,
  output logic [lpht_pkg::SlotW-1:0]   out_slot_o
);
  import lpht_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_SLOTS);
  localparam int unsigned CapW = IdxW + 1;
  localparam int unsigned AddrW = IdxW + 1;
  localparam int unsigned EntW = 1 + HashW + KEY_BITS + ValW;
  localparam int unsigned FirstCap = (INITIAL_SLOTS < MAX_SLOTS) ? INITIAL_SLOTS : MAX_SLOTS;

  logic                op_q;
  logic [HashW-1:0]    hash_q, mv_hash_q;
  logic [KEY_BITS-1:0] key_q, mv_key_q;
  logic [ValW-1:0]     val_q, mv_val_q;
  logic [CapW-1:0]     cap_q, ocap_q, cnt_q, clr_q, scan_q, n_q;
  logic                bank_q, obank_q;
  logic [IdxW-1:0]     idx_q;
  lpht_status_e        res_code_q;
  logic [ValW-1:0]     res_val_q;
  logic [SlotW-1:0]    res_slot_q;
  logic                out_valid_q;
  lpht_status_e        out_code_q;
  logic [ValW-1:0]     out_val_q;
  logic [SlotW-1:0]    out_slot_q;

  logic                we, re;
  logic [AddrW-1:0]    waddr, raddr;
  logic [EntW-1:0]     wdata, rdata;
  logic                rd_used;
  logic [HashW-1:0]    rd_hash, p_hash, mod_dvd;
  logic [KEY_BITS-1:0] rd_key, p_key;
  logic [ValW-1:0]     rd_val, p_val;
  logic [CapW-1:0]     rem;
  logic                mod_done;
  logic [CapW-1:0]     idx_inc;
  logic [CapW:0]       cap_dbl;

  assign {rd_used, rd_hash, rd_key, rd_val} = rdata;

  assign p_hash = cmd_i.src_moved ? mv_hash_q : hash_q;
  assign p_key  = cmd_i.src_moved ? mv_key_q : key_q;
  assign p_val  = cmd_i.src_moved ? mv_val_q : val_q;

  assign we    = cmd_i.clr_step | cmd_i.place;
  assign waddr = cmd_i.clr_step ? {bank_q, clr_q[IdxW-1:0]} : {bank_q, idx_q};
  assign wdata = cmd_i.clr_step ? '0 : {1'b1, p_hash, p_key, p_val};
  assign re    = cmd_i.scan_rd | cmd_i.probe_rd;
  assign raddr = cmd_i.scan_rd ? {obank_q, scan_q[IdxW-1:0]} : {bank_q, idx_q};

  lpht_ram #(
    .Width (EntW),
    .Depth (2 << IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign mod_dvd = cmd_i.scan_take ? rd_hash : p_hash;

  lpht_mod #(
    .DivW (CapW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (cap_q),
    .rem_o      (rem),
    .done_o     (mod_done)
  );

  assign idx_inc = {1'b0, idx_q} + CapW'(1);
  assign cap_dbl = {cap_q, 1'b0};

  always_comb begin
    st_o            = '0;
    st_o.op_insert  = op_q;
    st_o.hash_zero  = (hash_q == '0);
    st_o.cap_zero   = (cap_q == '0);
    st_o.want_grow  = (cnt_q >= (cap_q >> 1)) && (cap_dbl <= (CapW+1)'(MAX_SLOTS));
    st_o.full       = (cnt_q >= cap_q);
    st_o.clr_last   = (clr_q == cap_q - CapW'(1));
    st_o.scan_end   = (scan_q == ocap_q);
    st_o.rd_used    = rd_used;
    st_o.rd_match   = (rd_hash == hash_q) && (rd_key == key_q);
    st_o.probe_last = (n_q + CapW'(1) == cap_q);
    st_o.mod_done   = mod_done;
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  // table size, bank, count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= '0;
      cnt_q       <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.alloc) begin
        cap_q <= CapW'(FirstCap);
        cnt_q <= '0;
      end else if (cmd_i.grow) begin
        cap_q  <= cap_dbl[CapW-1:0];
        cnt_q  <= '0;
        bank_q <= ~bank_q;
      end else if (cmd_i.place) begin
        cnt_q <= cnt_q + CapW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_op_i;
      hash_q <= in_hash_i;
      key_q  <= in_key_i[KEY_BITS-1:0];
      val_q  <= in_val_i;
    end
    if (cmd_i.alloc || cmd_i.grow) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + CapW'(1);
    end
    if (cmd_i.grow) begin
      ocap_q  <= cap_q;
      obank_q <= bank_q;
      scan_q  <= '0;
    end else if (cmd_i.scan_next) begin
      scan_q <= scan_q + CapW'(1);
    end
    if (cmd_i.scan_take) begin
      mv_hash_q <= rd_hash;
      mv_key_q  <= rd_key;
      mv_val_q  <= rd_val;
    end
    if (cmd_i.probe_start) begin
      idx_q <= rem[IdxW-1:0];
      n_q   <= '0;
    end else if (cmd_i.probe_next) begin
      idx_q <= (idx_inc == cap_q) ? '0 : idx_inc[IdxW-1:0];
      n_q   <= n_q + CapW'(1);
    end
    if (cmd_i.set_res) begin
      res_code_q <= cmd_i.code;
      res_val_q  <= (cmd_i.code == ST_FOUND) ? rd_val : '0;
      res_slot_q <= (cmd_i.code == ST_FOUND || cmd_i.code == ST_INSERTED) ?
                    SlotW'(idx_q) : '0;
    end
    if (cmd_i.emit) begin
      out_code_q <= res_code_q;
      out_val_q  <= res_val_q;
      out_slot_q <= res_slot_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_code_q;
  assign out_value_o  = out_val_q;
  assign out_slot_o   = out_slot_q;

endmodule

>>> hdl/linear_probe_hash_table_core.sv
// Top level of the linear probing hash table: stream ports, controller and datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
//
// One word in gives one word out; a new word is taken once the previous one has been
// worked off, even while its result still waits in the output register. A lookup or a
// plain insert runs the bit-serial remainder of hash by capacity, then one registered
// memory read per probe. The first insert also clears INITIAL_SLOTS slots, one per
// cycle. An insert that finds the table at least half full doubles it, if the doubled
// size fits in MAX_SLOTS: it clears the new bank, scans every old slot, and runs a
// remainder plus probe for every entry moved. All slot data sits in one single-read,
// single-write memory of two banks, each of MAX_SLOTS rounded up to a power of two.
module linear_probe_hash_table_core #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned INITIAL_SLOTS = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // hash_code, name_key, entry_value
  input  logic         s_axis_tuser_i,   // op
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [47:0]  m_axis_tdata_o,   // found_value, slot_index, zero fill
  output logic [2:0]   m_axis_tuser_o    // status
);
  import lpht_pkg::*;

  lpht_cmd_t        cmd;
  lpht_stat_t       st;
  logic [ValW-1:0]  out_value;
  logic [SlotW-1:0] out_slot;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  lpht_dp #(
    .MAX_SLOTS     (MAX_SLOTS),
    .INITIAL_SLOTS (INITIAL_SLOTS),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .in_op_i      (s_axis_tuser_i),
    .in_hash_i    (s_axis_tdata_i[31:0]),
    .in_key_i     (s_axis_tdata_i[95:32]),
    .in_val_i     (s_axis_tdata_i[127:96]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_value_o  (out_value),
    .out_slot_o   (out_slot)
  );

  assign s_axis_tready_o = cmd.ready;
  assign m_axis_tdata_o  = {6'd0, out_slot, out_value};

endmodule
